### hdl/mlkcmp_pkg.sv
// ----------------------------------------------------------------------------
// mlkcmp_pkg
// shared types, constants and arithmetic for the ml-kem compress/pack block
// ----------------------------------------------------------------------------
package mlkcmp_pkg;

  localparam logic [11:0] MODULUS      = 12'd3329;
  localparam logic [14:0] COMPRESS_MUL = 15'd20159;
  localparam logic [11:0] D1_LO        = 12'((3329 - 1) / 2 - (3329 - 1) / 4 + 1);
  localparam logic [11:0] D1_HI        = 12'((3329 - 1) / 2 + (3329 - 1) / 4);
  localparam logic [11:0] HALF_Q       = 12'((3329 + 1) / 2);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] MODE_1BIT = 2'd0;
  localparam logic [1:0] MODE_4BIT = 2'd1;
  localparam logic [1:0] MODE_5BIT = 2'd2;
  localparam logic [1:0] MODE_RESET = MODE_4BIT;

  typedef enum logic {
    OP_COMPRESS   = 1'b0,
    OP_DECOMPRESS = 1'b1
  } opcode_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_COEF = 1'b1
  } kind_t;

  // one unit of work for the back part
  typedef struct packed {
    kind_t       kind;
    logic [11:0] bits;
    logic [3:0]  count;
    logic [1:0]  mode;
  } job_t;

  function automatic logic [2:0] bits_per_coef(input logic [1:0] mode);
    logic [2:0] d;
    unique case (mode)
      MODE_1BIT: d = 3'd1;
      MODE_4BIT: d = 3'd4;
      default:   d = 3'd5;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] compress_value(input logic [11:0] x,
                                                input logic [1:0]  mode);
    logic [11:0] xc;
    logic [26:0] prod;
    logic [10:0] t;
    logic [11:0] t4;
    logic [11:0] t5;
    logic [4:0]  v;
    xc   = (x > MODULUS) ? MODULUS : x;
    prod = {15'd0, xc} * {12'd0, COMPRESS_MUL};
    t    = prod[26:16];
    t4   = {1'b0, t} + 12'd32;
    t5   = {1'b0, t} + 12'd16;
    unique case (mode)
      MODE_1BIT: v = {4'd0, (xc >= D1_LO) && (xc <= D1_HI)};
      MODE_4BIT: v = {1'b0, t4[9:6]};
      default:   v = t5[9:5];
    endcase
    return v;
  endfunction

  function automatic logic [11:0] decompress_value(input logic [4:0] y,
                                                   input logic [1:0] mode);
    logic [16:0] p;
    logic [16:0] r;
    logic [11:0] v;
    unique case (mode)
      MODE_1BIT: begin
        p = 17'd0;
        r = 17'd0;
        v = y[0] ? HALF_Q : 12'd0;
      end
      MODE_4BIT: begin
        p = {13'd0, y[3:0]} * {5'd0, MODULUS};
        r = p + 17'd8;
        v = r[15:4];
      end
      default: begin
        p = {12'd0, y} * {5'd0, MODULUS};
        r = p + 17'd16;
        v = r[16:5];
      end
    endcase
    return v;
  endfunction

endpackage

### hdl/mlkcmp_front.sv
// ----------------------------------------------------------------------------
// mlkcmp_front
// accepts items, keeps the bit accumulator and hands jobs to the queue
// ----------------------------------------------------------------------------
module mlkcmp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_data,
  input  logic                 accept,
  input  mlkcmp_pkg::opcode_t  opcode,
  input  logic [11:0]          coefficient,
  input  logic [7:0]           pbyte,
  output logic                 push,
  output mlkcmp_pkg::job_t     job
);

  logic [1:0]          width_mode_r, width_mode_nxt;
  logic [11:0]         acc_r, acc_nxt;
  logic [3:0]          fill_r, fill_nxt;
  mlkcmp_pkg::opcode_t prev_op_r, prev_op_nxt;

  logic [2:0]  d;
  logic [11:0] acc_base;
  logic [3:0]  fill_base;
  logic [4:0]  cv;
  logic [11:0] acc_sum;
  logic [3:0]  fill_sum;
  logic [3:0]  nres;
  logic [3:0]  consumed;

  always_comb begin
    d         = mlkcmp_pkg::bits_per_coef(width_mode_r);
    acc_base  = (opcode != prev_op_r) ? 12'd0 : acc_r;
    fill_base = (opcode != prev_op_r) ? 4'd0 : fill_r;
    cv        = mlkcmp_pkg::compress_value(coefficient, width_mode_r);
    nres      = 4'd0;
    consumed  = 4'd0;
    if (opcode == mlkcmp_pkg::OP_COMPRESS) begin
      acc_sum  = acc_base | (12'(cv) << fill_base);
      fill_sum = fill_base + {1'b0, d};
      if (fill_sum >= 4'd8) begin
        nres     = 4'd1;
        consumed = 4'd8;
      end
    end else begin
      acc_sum  = acc_base | (12'(pbyte) << fill_base);
      fill_sum = fill_base + 4'd8;
      unique case (width_mode_r)
        mlkcmp_pkg::MODE_1BIT: begin
          nres     = (fill_sum > 4'd8) ? 4'd8 : fill_sum;
          consumed = nres;
        end
        mlkcmp_pkg::MODE_4BIT: begin
          nres     = {2'b00, fill_sum[3:2]};
          consumed = {fill_sum[3:2], 2'b00};
        end
        default: begin
          if (fill_sum >= 4'd15) begin
            nres     = 4'd3;
            consumed = 4'd15;
          end else if (fill_sum >= 4'd10) begin
            nres     = 4'd2;
            consumed = 4'd10;
          end else begin
            nres     = 4'd1;
            consumed = 4'd5;
          end
        end
      endcase
    end
  end

  always_comb begin
    push     = accept && (nres != 4'd0);
    job.kind = (opcode == mlkcmp_pkg::OP_COMPRESS) ? mlkcmp_pkg::KIND_BYTE
                                                   : mlkcmp_pkg::KIND_COEF;
    job.bits  = acc_sum;
    job.count = nres;
    job.mode  = width_mode_r;
  end

  always_comb begin
    width_mode_nxt = width_mode_r;
    acc_nxt        = acc_r;
    fill_nxt       = fill_r;
    prev_op_nxt    = prev_op_r;
    if (cfg_valid) begin
      width_mode_nxt = cfg_data;
      acc_nxt        = 12'd0;
      fill_nxt       = 4'd0;
    end else if (accept) begin
      acc_nxt     = acc_sum >> consumed;
      fill_nxt    = fill_sum - consumed;
      prev_op_nxt = opcode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= mlkcmp_pkg::MODE_RESET;
      acc_r        <= 12'd0;
      fill_r       <= 4'd0;
      prev_op_r    <= mlkcmp_pkg::OP_COMPRESS;
    end else begin
      width_mode_r <= width_mode_nxt;
      acc_r        <= acc_nxt;
      fill_r       <= fill_nxt;
      prev_op_r    <= prev_op_nxt;
    end
  end

endmodule

### hdl/mlkcmp_queue.sv
// ----------------------------------------------------------------------------
// mlkcmp_queue
// short job queue between the front and the back part
// ----------------------------------------------------------------------------
module mlkcmp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mlkcmp_pkg::job_t  job_in,
  input  logic              pop,
  output mlkcmp_pkg::job_t  head,
  output logic              not_empty,
  output logic              full
);

  mlkcmp_pkg::job_t mem_r [mlkcmp_pkg::QUEUE_DEPTH];

  logic [mlkcmp_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mlkcmp_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mlkcmp_pkg::QPTR_W:0]   cnt_r, cnt_nxt;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (mlkcmp_pkg::QPTR_W + 1)'(mlkcmp_pkg::QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/mlkcmp_back.sv
// ----------------------------------------------------------------------------
// mlkcmp_back
// unpacks jobs into results, one per unstalled cycle, via an output register
// ----------------------------------------------------------------------------
module mlkcmp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mlkcmp_pkg::job_t  head,
  input  logic              q_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output mlkcmp_pkg::kind_t out_kind,
  output logic [7:0]        out_byte,
  output logic [11:0]       out_coef,
  output logic              out_last
);

  logic              wk_valid_r, wk_valid_nxt;
  mlkcmp_pkg::kind_t wk_kind_r, wk_kind_nxt;
  logic [11:0]       wk_bits_r, wk_bits_nxt;
  logic [3:0]        wk_left_r, wk_left_nxt;
  logic [1:0]        wk_mode_r, wk_mode_nxt;

  logic              out_valid_r, out_valid_nxt;
  mlkcmp_pkg::kind_t out_kind_r, out_kind_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic [11:0]       out_coef_r, out_coef_nxt;
  logic              out_last_r, out_last_nxt;

  logic       out_load;
  logic       wk_last;
  logic [2:0] d;

  always_comb begin
    d        = mlkcmp_pkg::bits_per_coef(wk_mode_r);
    out_load = wk_valid_r && (!out_valid_r || out_ready);
    wk_last  = (wk_left_r == 4'd1);
    pop      = q_valid && (!wk_valid_r || (out_load && wk_last));
  end

  // working register
  always_comb begin
    wk_valid_nxt = wk_valid_r;
    wk_kind_nxt  = wk_kind_r;
    wk_bits_nxt  = wk_bits_r;
    wk_left_nxt  = wk_left_r;
    wk_mode_nxt  = wk_mode_r;
    if (pop) begin
      wk_valid_nxt = 1'b1;
      wk_kind_nxt  = head.kind;
      wk_bits_nxt  = head.bits;
      wk_left_nxt  = head.count;
      wk_mode_nxt  = head.mode;
    end else if (out_load) begin
      if (wk_last) begin
        wk_valid_nxt = 1'b0;
      end else begin
        wk_bits_nxt = wk_bits_r >> d;
        wk_left_nxt = wk_left_r - 4'd1;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_coef_nxt  = out_coef_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = wk_kind_r;
      if (wk_kind_r == mlkcmp_pkg::KIND_BYTE) begin
        out_byte_nxt = wk_bits_r[7:0];
        out_coef_nxt = 12'd0;
        out_last_nxt = 1'b1;
      end else begin
        out_byte_nxt = 8'd0;
        out_coef_nxt = mlkcmp_pkg::decompress_value(wk_bits_r[4:0], wk_mode_r);
        out_last_nxt = wk_last;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wk_valid_r  <= wk_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_kind_r  <= wk_kind_nxt;
    wk_bits_r  <= wk_bits_nxt;
    wk_left_r  <= wk_left_nxt;
    wk_mode_r  <= wk_mode_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_coef_r <= out_coef_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_coef  = out_coef_r;
  assign out_last  = out_last_r;

`ifndef SYNTH
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    wk_valid_r |-> (wk_left_r != 4'd0) && (wk_left_r <= 4'd8))
    else $error("working job has no results left");

  a_byte_single: assert property (@(posedge clk) disable iff (!rst_n)
    wk_valid_r && (wk_kind_r == mlkcmp_pkg::KIND_BYTE) |-> wk_left_r == 4'd1)
    else $error("packed byte job with more than one result");

  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == mlkcmp_pkg::KIND_COEF) |-> out_coef_r < mlkcmp_pkg::MODULUS)
    else $error("decompressed coefficient out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> wk_valid_r)
    else $error("popped job not held in working register");
`endif

endmodule

### hdl/mlkem_coefficient_compress_pack.sv
// ----------------------------------------------------------------------------
// mlkem_coefficient_compress_pack
// ml-kem coefficient compress/pack and unpack/decompress, q = 3329, d = 1/4/5
// a result goes through job queue, working register and output register
// throughput: one input per cycle while each input gives at most one result
// and out_tready is high; the back part emits one result per unstalled cycle;
// a byte gives 8/2/1-2 results (d=1/4/5); a 4-entry job queue absorbs bursts
// reset: synchronous active-low rst_n; width mode 4 bits, accumulator empty
// ----------------------------------------------------------------------------
module mlkem_coefficient_compress_pack (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // in_coefficient[11:0], in_byte[19:12], zero
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_byte[7:0], out_coefficient[19:8], zero
  output logic        out_tuser,  // result_kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  logic              q_full;
  logic              q_valid;
  logic              push;
  logic              pop;
  logic              accept;
  mlkcmp_pkg::job_t  job;
  mlkcmp_pkg::job_t  head;
  mlkcmp_pkg::kind_t res_kind;
  logic [7:0]        res_byte;
  logic [11:0]       res_coef;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  mlkcmp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .opcode      (mlkcmp_pkg::opcode_t'(in_tuser)),
    .coefficient (in_tdata[11:0]),
    .pbyte       (in_tdata[19:12]),
    .push        (push),
    .job         (job)
  );

  mlkcmp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .job_in    (job),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  mlkcmp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_valid   (q_valid),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (res_kind),
    .out_byte  (res_byte),
    .out_coef  (res_coef),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'd0, res_coef, res_byte};
  assign out_tuser = (res_kind == mlkcmp_pkg::KIND_COEF);

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ml-kem coefficient compress/pack block: a
// scoreboard tracks the bit accumulator, opcode and width mode, predicts the
// packed bytes and decompressed coefficients of each input transfer and
// checks every result transfer in order; random idling on both streams
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Q            = 3329;
  localparam logic [1:0]  MODE_5BIT_ALT = 2'd3;

  class pack_scoreboard;
    typedef struct {
      mlkcmp_pkg::kind_t kind;
      logic [7:0]        packed_byte;
      logic [11:0]       coef;
      logic              last;
    } result_t;

    result_t             pending_results[$];
    logic [1:0]          mode;
    logic [11:0]         acc;
    logic [3:0]          fill;
    mlkcmp_pkg::opcode_t last_op;
    int                  errors;

    function new();
      mode    = mlkcmp_pkg::MODE_RESET;
      acc     = '0;
      fill    = '0;
      last_op = mlkcmp_pkg::OP_COMPRESS;
      errors  = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void note_config(logic [1:0] value);
      mode = value;
      acc  = '0;
      fill = '0;
    endfunction

    function int unsigned width_bits();
      if (mode == mlkcmp_pkg::MODE_1BIT) return 1;
      if (mode == mlkcmp_pkg::MODE_4BIT) return 4;
      return 5;
    endfunction

    function int unsigned squeeze_coef(logic [11:0] x, int unsigned d);
      int unsigned xc;
      int unsigned t;
      xc = (x > Q) ? Q : x;
      if (d == 1) return (xc >= (Q - 1) / 2 - (Q - 1) / 4 + 1 &&
                          xc <= (Q - 1) / 2 + (Q - 1) / 4) ? 1 : 0;
      t = (xc * 20159) >> 16;
      if (d == 4) return ((t + 32) >> 6) & 15;
      return ((t + 16) >> 5) & 31;
    endfunction

    function logic [11:0] expand_value(int unsigned y, int unsigned d);
      int unsigned v;
      v = (y * Q + (1 << (d - 1))) >> d;
      return v[11:0];
    endfunction

    // predict the results of one accepted input transfer
    function void note_transfer(mlkcmp_pkg::opcode_t op, logic [11:0] coef_in,
                                logic [7:0] byte_in);
      int unsigned d;
      int unsigned a;
      int unsigned f;
      int unsigned n;
      result_t     r;
      d = width_bits();
      n = 0;
      if (op != last_op) begin
        acc  = '0;
        fill = '0;
      end
      last_op = op;
      if (op == mlkcmp_pkg::OP_COMPRESS) begin
        a = acc | (squeeze_coef(coef_in, d) << fill);
        acc = a[11:0];
        f = fill + d;
        if (f >= 8) begin
          r = '{mlkcmp_pkg::KIND_BYTE, acc[7:0], 12'd0, 1'b0};
          pending_results.push_back(r);
          n++;
          acc = acc >> 8;
          f -= 8;
        end
      end else begin
        a = acc | (byte_in << fill);
        acc = a[11:0];
        f = fill + 8;
        while (f >= d && n < 8) begin
          r = '{mlkcmp_pkg::KIND_COEF, 8'd0, expand_value(acc & ((1 << d) - 1), d), 1'b0};
          pending_results.push_back(r);
          n++;
          acc = acc >> d;
          f -= d;
        end
      end
      fill = f[3:0];
      if (n > 0) pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    function void check_transfer(logic kind, logic [7:0] b, logic [11:0] c, logic last);
      result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d byte=%0h coef=%0d last=%0d", kind, b, c, last);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (kind !== e.kind) begin
        $error("result_kind expected %0d actual %0d", e.kind, kind);
        errors++;
      end
      if (b !== e.packed_byte) begin
        $error("out_byte expected %0h actual %0h", e.packed_byte, b);
        errors++;
      end
      if (c !== e.coef) begin
        $error("out_coefficient expected %0d actual %0d", e.coef, c);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run expected %0d actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // in_coefficient[11:0], in_byte[19:12], zero
  logic        in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // out_byte[7:0], out_coefficient[19:8], zero
  logic        out_tuser;  // result_kind
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;

  bit             idle_on = 1'b1;
  pack_scoreboard sb = new();

  mlkem_coefficient_compress_pack u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_transfer(mlkcmp_pkg::opcode_t'(in_tuser), in_tdata[11:0], in_tdata[19:12]);
      if (out_tvalid && out_tready)
        sb.check_transfer(out_tuser, out_tdata[7:0], out_tdata[19:8], out_tlast);
    end
  end

  // result side back-pressure
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic push_item(input mlkcmp_pkg::opcode_t op, input logic [11:0] coef,
                           input logic [7:0] pb);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, pb, coef};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_mode(input logic [1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.note_config(value);
  endtask

  function automatic logic [11:0] pick_coef();
    int unsigned sel;
    int unsigned corners[7];
    corners = '{0, 832, 833, 2496, 2497, 3328, 3329};
    sel = $urandom_range(0, 9);
    if (sel == 0) return 12'($urandom_range(0, 4095));
    if (sel == 1) return 12'(corners[$urandom_range(0, 6)]);
    return 12'($urandom_range(0, Q - 1));
  endfunction

  // mostly whole runs of one opcode, some short broken runs
  task automatic random_items(input int unsigned budget);
    int unsigned         sent;
    int unsigned         len;
    mlkcmp_pkg::opcode_t op;
    sent = 0;
    while (sent < budget) begin
      op  = mlkcmp_pkg::opcode_t'($urandom_range(0, 1));
      len = (op == mlkcmp_pkg::OP_COMPRESS) ? 8 * $urandom_range(1, 2) : $urandom_range(1, 6);
      if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 3);
      repeat (len) begin
        push_item(op, pick_coef(), 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [11:0] corner_coefs[8];
    logic [1:0]  plan[6];
    corner_coefs = '{12'd0, 12'd3328, 12'd3329, 12'd4095,
                     12'd832, 12'd833, 12'd2496, 12'd2497};
    plan = '{mlkcmp_pkg::MODE_5BIT, mlkcmp_pkg::MODE_1BIT, MODE_5BIT_ALT,
             mlkcmp_pkg::MODE_4BIT, mlkcmp_pkg::MODE_1BIT, mlkcmp_pkg::MODE_5BIT};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width mode: corners, clamp, opcode switch drops pending bits
    foreach (corner_coefs[i]) push_item(mlkcmp_pkg::OP_COMPRESS, corner_coefs[i], 8'd0);
    push_item(mlkcmp_pkg::OP_DECOMPRESS, 12'd0, 8'h00);
    push_item(mlkcmp_pkg::OP_DECOMPRESS, 12'd0, 8'hFF);
    push_item(mlkcmp_pkg::OP_COMPRESS, 12'd1000, 8'd0);
    push_item(mlkcmp_pkg::OP_DECOMPRESS, 12'd0, 8'hA5);

    write_mode(mlkcmp_pkg::MODE_1BIT);
    foreach (corner_coefs[i]) push_item(mlkcmp_pkg::OP_COMPRESS, corner_coefs[i], 8'd0);
    push_item(mlkcmp_pkg::OP_DECOMPRESS, 12'd0, 8'h5A);

    write_mode(MODE_5BIT_ALT);
    push_item(mlkcmp_pkg::OP_COMPRESS, 12'd4095, 8'd0);
    push_item(mlkcmp_pkg::OP_COMPRESS, 12'd3328, 8'd0);
    push_item(mlkcmp_pkg::OP_DECOMPRESS, 12'd0, 8'hFF);
    push_item(mlkcmp_pkg::OP_DECOMPRESS, 12'd0, 8'h3C);

    foreach (plan[i]) begin
      write_mode(plan[i]);
      random_items(28);
    end

    write_mode(2'($urandom_range(0, 3)));
    idle_on = 1'b0;
    random_items(28);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### files.f
hdl/mlkcmp_pkg.sv
hdl/mlkcmp_front.sv
hdl/mlkcmp_queue.sv
hdl/mlkcmp_back.sv
hdl/mlkem_coefficient_compress_pack.sv
tb/tb_top.sv
